/* rtl/motor_window_fault_monitor_unit_macros.svh */
// Assertion macros for the motor window fault monitor.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef MOTOR_WINDOW_FAULT_MONITOR_UNIT_MACROS_SVH
`define MOTOR_WINDOW_FAULT_MONITOR_UNIT_MACROS_SVH

// same-cycle implication, reset masked
`define MWFM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define MWFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mwfm_pkg.sv */
// Shared types, constants and helper functions for the motor window fault monitor.
// Depends on nothing.
package mwfm_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int TIME_W           = 47;
  localparam int CODE_W           = 12;
  localparam int CNT_W            = 32;
  localparam int DIAG_W           = 7;
  localparam int NUM_CH           = 4;
  localparam int NUM_REGS         = 8;
  localparam int REG_IDX_W        = 3;
  localparam int CFG_IDX_W        = 4;

  localparam int CH_TEMP  = 0;
  localparam int CH_VOLT  = 1;
  localparam int CH_CURR  = 2;
  localparam int CH_SPEED = 3;

  localparam logic [CODE_W-1:0] CODE_NONE = 12'd2222;

  localparam int DIAG_OFF       = 0;
  localparam int DIAG_COLD      = 1;
  localparam int DIAG_OVERHEAT  = 2;
  localparam int DIAG_UNDERVOLT = 3;
  localparam int DIAG_OVERVOLT  = 4;
  localparam int DIAG_OVERLOAD  = 5;
  localparam int DIAG_BLOCKED   = 6;

  typedef enum logic [1:0] {
    WIN_OFF  = 2'd0,
    WIN_LOW  = 2'd1,
    WIN_NORM = 2'd2,
    WIN_HIGH = 2'd3
  } win_code_t;

  typedef struct packed {
    win_code_t t;
    win_code_t v;
    win_code_t c;
    win_code_t s;
  } mwfm_codes_t;

  typedef struct packed {
    mwfm_codes_t             codes;
    logic [CODE_W-1:0]       fault_code;
    logic                    in_limits;
    logic                    new_report;
    logic [DIAG_W-1:0]       diagnosis;
    logic [CNT_W-1:0]        normal_total;
    logic [CNT_W-1:0]        fault_total;
    logic [TIME_W-1:0]       fault_time;
  } mwfm_result_t;

  function automatic logic [CODE_W-1:0] pack_code(input mwfm_codes_t cd);
    logic [CODE_W-1:0] sum;
    sum = CODE_W'(cd.t) * CODE_W'(1000) + CODE_W'(cd.v) * CODE_W'(100)
        + CODE_W'(cd.c) * CODE_W'(10) + CODE_W'(cd.s);
    return sum;
  endfunction

  function automatic logic [DIAG_W-1:0] diag_bits(input mwfm_codes_t cd);
    logic [DIAG_W-1:0] d;
    d = '0;
    if (cd.v == WIN_OFF) begin
      d[DIAG_OFF] = 1'b1;
    end else begin
      d[DIAG_COLD]      = (cd.t == WIN_LOW);
      d[DIAG_OVERHEAT]  = (cd.t == WIN_HIGH);
      d[DIAG_UNDERVOLT] = (cd.v == WIN_LOW);
      d[DIAG_OVERVOLT]  = (cd.v == WIN_HIGH);
      d[DIAG_OVERLOAD]  = (cd.c == WIN_HIGH) && (cd.s == WIN_LOW);
      d[DIAG_BLOCKED]   = (cd.c == WIN_HIGH) && (cd.s == WIN_OFF);
    end
    return d;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + CNT_W'(1);
  endfunction

endpackage

/* rtl/mwfm_limits.sv */
// Limit register file: max/min window bounds per channel, written over the cfg port.
// Depends on mwfm_pkg.
module mwfm_limits
  import mwfm_pkg::*;
#(
  parameter int SW = SAMPLE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [SW-1:0]        wr_data,
  output logic signed [SW-1:0] lim_max [NUM_CH],
  output logic signed [SW-1:0] lim_min [NUM_CH]
);

  localparam logic [SW-1:0] TOP_VAL = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] BOT_VAL = {1'b1, {(SW-1){1'b0}}};

  logic [SW-1:0] lim_r [NUM_REGS];
  logic          hit;

  assign hit = wr_en && (wr_index < CFG_IDX_W'(NUM_REGS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        lim_r[i] <= (i % 2 == 0) ? TOP_VAL : BOT_VAL;
      end
    end else if (hit) begin
      lim_r[wr_index[REG_IDX_W-1:0]] <= wr_data;
    end
  end

  // even index holds max, odd index holds min
  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_out
    assign lim_max[ch] = $signed(lim_r[2*ch]);
    assign lim_min[ch] = $signed(lim_r[2*ch+1]);
  end

endmodule

/* rtl/mwfm_window.sv */
// Window classifier for one channel: off, low, normal or high.
// Depends on mwfm_pkg.
module mwfm_window
  import mwfm_pkg::*;
#(
  parameter int SW = SAMPLE_WIDTH_DEF
) (
  input  logic signed [SW-1:0] sample,
  input  logic signed [SW-1:0] lim_hi,
  input  logic signed [SW-1:0] lim_lo,
  output win_code_t            code
);

  always_comb begin
    if (sample == '0) begin
      code = WIN_OFF;
    end else if (sample > lim_hi) begin
      code = WIN_HIGH;
    end else if (sample < lim_lo) begin
      code = WIN_LOW;
    end else begin
      code = WIN_NORM;
    end
  end

endmodule

/* rtl/mwfm_track.sv */
// Fault tracking and result register: counters, last fault code, diagnosis.
// Depends on mwfm_pkg.
module mwfm_track
  import mwfm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  mwfm_codes_t        codes,
  input  logic [TIME_W-1:0]  sample_time,
  input  logic               out_ready,
  output logic               take,
  output logic               out_valid,
  output mwfm_result_t       res
);

  logic [CNT_W-1:0]  normal_cnt_r, normal_cnt_nxt;
  logic [CNT_W-1:0]  fault_cnt_r, fault_cnt_nxt;
  logic [CODE_W-1:0] last_code_r, last_code_nxt;
  logic              out_valid_r, out_valid_nxt;
  mwfm_result_t      res_r, res_nxt;
  logic [CODE_W-1:0] code;
  logic              ok;
  logic              fresh;

  assign take = !out_valid_r || out_ready;
  assign code = pack_code(codes);
  assign ok   = (codes.t == WIN_NORM) && (codes.v == WIN_NORM)
             && (codes.c == WIN_NORM) && (codes.s == WIN_NORM);
  assign fresh = !ok && (code != last_code_r);

  always_comb begin
    normal_cnt_nxt = normal_cnt_r;
    fault_cnt_nxt  = fault_cnt_r;
    last_code_nxt  = last_code_r;
    if (load) begin
      if (ok) begin
        normal_cnt_nxt = sat_inc(normal_cnt_r);
      end else begin
        fault_cnt_nxt = sat_inc(fault_cnt_r);
      end
      if (fresh) begin
        last_code_nxt = code;
      end
    end

    res_nxt              = res_r;
    res_nxt.codes        = codes;
    res_nxt.fault_code   = code;
    res_nxt.in_limits    = ok;
    res_nxt.new_report   = fresh;
    res_nxt.diagnosis    = ok ? '0 : diag_bits(codes);
    res_nxt.normal_total = normal_cnt_nxt;
    res_nxt.fault_total  = fault_cnt_nxt;
    res_nxt.fault_time   = ok ? '0 : sample_time;

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_cnt_r <= '0;
      fault_cnt_r  <= '0;
      last_code_r  <= CODE_NONE;
      out_valid_r  <= 1'b0;
    end else begin
      normal_cnt_r <= normal_cnt_nxt;
      fault_cnt_r  <= fault_cnt_nxt;
      last_code_r  <= last_code_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

/* rtl/motor_window_fault_monitor_unit.sv */
// Top level of the motor window fault monitor.
// Depends on mwfm_pkg, mwfm_limits, mwfm_window, mwfm_track and the macros header.
//
// Takes one sample word per clock and returns one result word per sample, in order.
// A word passes an input register and then a result register before its result
// is offered; a stall can hold it in either. Throughput is one word per cycle, limited
// only by out_ready, which reaches in_ready in the same cycle. Limits are written
// through the cfg port (index 0..7: temp max/min, volt, curr, speed); indexes
// above 7 are ignored. Write them only while no word is in flight.
`include "motor_window_fault_monitor_unit_macros.svh"

module motor_window_fault_monitor_unit
  import mwfm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [TIME_W-1:0]              in_sample_time,
  input  logic signed [SAMPLE_WIDTH-1:0] in_temperature,
  input  logic signed [SAMPLE_WIDTH-1:0] in_voltage,
  input  logic signed [SAMPLE_WIDTH-1:0] in_current,
  input  logic signed [SAMPLE_WIDTH-1:0] in_speed,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_temp_code,
  output logic [1:0]                     out_volt_code,
  output logic [1:0]                     out_curr_code,
  output logic [1:0]                     out_speed_code,
  output logic [CODE_W-1:0]              out_fault_code,
  output logic                           out_in_limits,
  output logic                           out_new_report,
  output logic [DIAG_W-1:0]              out_diagnosis,
  output logic [CNT_W-1:0]               out_normal_total,
  output logic [CNT_W-1:0]               out_fault_total,
  output logic [TIME_W-1:0]              out_fault_time,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [SAMPLE_WIDTH-1:0]        cfg_data
);

  localparam int SW = SAMPLE_WIDTH;

  logic                 s1_valid_r, s1_valid_nxt;
  logic [TIME_W-1:0]    s1_time_r;
  logic signed [SW-1:0] s1_smp_r [NUM_CH];
  logic signed [SW-1:0] lim_max [NUM_CH];
  logic signed [SW-1:0] lim_min [NUM_CH];
  win_code_t            ch_code [NUM_CH];
  mwfm_codes_t          codes;
  mwfm_result_t         res;
  logic                 take;
  logic                 s1_adv;
  logic                 in_fire;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid_r && take;
  assign in_ready  = !s1_valid_r || take;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_time_r          <= in_sample_time;
      s1_smp_r[CH_TEMP]  <= in_temperature;
      s1_smp_r[CH_VOLT]  <= in_voltage;
      s1_smp_r[CH_CURR]  <= in_current;
      s1_smp_r[CH_SPEED] <= in_speed;
    end
  end

  mwfm_limits #(.SW(SW)) u_limits (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .lim_max  (lim_max),
    .lim_min  (lim_min)
  );

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_win
    mwfm_window #(.SW(SW)) u_window (
      .sample (s1_smp_r[ch]),
      .lim_hi (lim_max[ch]),
      .lim_lo (lim_min[ch]),
      .code   (ch_code[ch])
    );
  end

  assign codes.t = ch_code[CH_TEMP];
  assign codes.v = ch_code[CH_VOLT];
  assign codes.c = ch_code[CH_CURR];
  assign codes.s = ch_code[CH_SPEED];

  mwfm_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (s1_adv),
    .codes       (codes),
    .sample_time (s1_time_r),
    .out_ready   (out_ready),
    .take        (take),
    .out_valid   (out_valid),
    .res         (res)
  );

  assign out_temp_code    = res.codes.t;
  assign out_volt_code    = res.codes.v;
  assign out_curr_code    = res.codes.c;
  assign out_speed_code   = res.codes.s;
  assign out_fault_code   = res.fault_code;
  assign out_in_limits    = res.in_limits;
  assign out_new_report   = res.new_report;
  assign out_diagnosis    = res.diagnosis;
  assign out_normal_total = res.normal_total;
  assign out_fault_total  = res.fault_total;
  assign out_fault_time   = res.fault_time;

  `MWFM_ASSERT_NOW(a_limits_clean, out_valid && out_in_limits, (out_fault_code == CODE_NONE) && !out_new_report && (out_fault_time == '0), "in-limit result carries fault fields")
  `MWFM_ASSERT_NOW(a_limits_no_diag, out_valid && out_in_limits, out_diagnosis == '0, "in-limit result has diagnosis bits")
  `MWFM_ASSERT_NEXT(a_held_item, s1_valid_r && !take, s1_valid_r, "stalled sample dropped from input register")
  `MWFM_ASSERT_NEXT(a_no_phantom, out_valid && out_ready && !s1_valid_r, !out_valid, "result appeared with no sample behind it")

endmodule

/* verif/motor_window_fault_monitor_unit_tb.sv */
// Self-checking bench for motor_window_fault_monitor_unit: directed and random samples
// under several limit settings, each result checked against an in-bench predictor.
// Depends on mwfm_pkg and the RTL of the block.
`timescale 1ns / 100ps

module motor_window_fault_monitor_unit_tb;
  import mwfm_pkg::*;

  localparam int SW            = SAMPLE_WIDTH_DEF;
  localparam int SMAX          = (1 << (SW - 1)) - 1;
  localparam int SMIN          = -(1 << (SW - 1));
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int CHUNK         = 52;
  localparam int CHUNKS        = 4;
  localparam logic [63:0] STAMP_TOP = 64'd99991231235959;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_MAX, REG_TEMP_MIN, REG_VOLT_MAX, REG_VOLT_MIN,
    REG_CURR_MAX, REG_CURR_MIN, REG_SPEED_MAX, REG_SPEED_MIN
  } lim_reg_t;

  typedef enum int {LIM_WIDE, LIM_INVERTED, LIM_ORDERED, LIM_SCRAMBLED, LIM_POINT} lim_mode_t;

  typedef struct packed {
    logic [TIME_W-1:0]    stamp;
    logic signed [SW-1:0] temp;
    logic signed [SW-1:0] volt;
    logic signed [SW-1:0] curr;
    logic signed [SW-1:0] speed;
  } sample_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [TIME_W-1:0]     in_sample_time = '0;
  logic signed [SW-1:0]  in_temperature = '0;
  logic signed [SW-1:0]  in_voltage = '0;
  logic signed [SW-1:0]  in_current = '0;
  logic signed [SW-1:0]  in_speed = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_temp_code;
  logic [1:0]            out_volt_code;
  logic [1:0]            out_curr_code;
  logic [1:0]            out_speed_code;
  logic [CODE_W-1:0]     out_fault_code;
  logic                  out_in_limits;
  logic                  out_new_report;
  logic [DIAG_W-1:0]     out_diagnosis;
  logic [CNT_W-1:0]      out_normal_total;
  logic [CNT_W-1:0]      out_fault_total;
  logic [TIME_W-1:0]     out_fault_time;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [SW-1:0]         cfg_data = '0;

  motor_window_fault_monitor_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample_time(in_sample_time), .in_temperature(in_temperature),
    .in_voltage(in_voltage), .in_current(in_current), .in_speed(in_speed),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_temp_code(out_temp_code), .out_volt_code(out_volt_code),
    .out_curr_code(out_curr_code), .out_speed_code(out_speed_code),
    .out_fault_code(out_fault_code), .out_in_limits(out_in_limits),
    .out_new_report(out_new_report), .out_diagnosis(out_diagnosis),
    .out_normal_total(out_normal_total), .out_fault_total(out_fault_total),
    .out_fault_time(out_fault_time),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state
  logic signed [SW-1:0] lim_hi [NUM_CH];
  logic signed [SW-1:0] lim_lo [NUM_CH];
  logic [CNT_W-1:0]     seen_normal;
  logic [CNT_W-1:0]     seen_fault;
  logic [CODE_W-1:0]    prev_fault_code;

  sample_t      pending [$];
  mwfm_result_t results_due [$];
  sample_t      cur_word;
  sample_t      last_gen;
  bit           in_taken = 1'b0;
  bit           no_idle = 1'b0;
  bit           hold_req = 1'b0;
  int           hold_left = 0;
  int           stall_cycles = 0;
  int           failures = 0;

  function automatic win_code_t classify(input logic signed [SW-1:0] x,
                                         input logic signed [SW-1:0] hi,
                                         input logic signed [SW-1:0] lo);
    if (x == 0) return WIN_OFF;
    if (x > hi) return WIN_HIGH;
    if (x < lo) return WIN_LOW;
    return WIN_NORM;
  endfunction

  function automatic mwfm_result_t judge_sample(input sample_t s);
    mwfm_result_t r;
    int           packed_val;
    logic         ok;
    r = '0;
    r.codes.t = classify(s.temp, lim_hi[CH_TEMP], lim_lo[CH_TEMP]);
    r.codes.v = classify(s.volt, lim_hi[CH_VOLT], lim_lo[CH_VOLT]);
    r.codes.c = classify(s.curr, lim_hi[CH_CURR], lim_lo[CH_CURR]);
    r.codes.s = classify(s.speed, lim_hi[CH_SPEED], lim_lo[CH_SPEED]);
    packed_val = int'(r.codes.t) * 1000 + int'(r.codes.v) * 100
               + int'(r.codes.c) * 10 + int'(r.codes.s);
    r.fault_code = CODE_W'(packed_val);
    ok = (r.codes.t == WIN_NORM) && (r.codes.v == WIN_NORM)
      && (r.codes.c == WIN_NORM) && (r.codes.s == WIN_NORM);
    r.in_limits = ok;
    if (ok) begin
      if (seen_normal != '1) seen_normal = seen_normal + 1'b1;
    end else begin
      if (seen_fault != '1) seen_fault = seen_fault + 1'b1;
      r.fault_time = s.stamp;
      if (r.fault_code != prev_fault_code) begin
        r.new_report = 1'b1;
        prev_fault_code = r.fault_code;
      end
      if (r.codes.v == WIN_OFF) begin
        r.diagnosis[DIAG_OFF] = 1'b1;
      end else begin
        r.diagnosis[DIAG_COLD]      = (r.codes.t == WIN_LOW);
        r.diagnosis[DIAG_OVERHEAT]  = (r.codes.t == WIN_HIGH);
        r.diagnosis[DIAG_UNDERVOLT] = (r.codes.v == WIN_LOW);
        r.diagnosis[DIAG_OVERVOLT]  = (r.codes.v == WIN_HIGH);
        r.diagnosis[DIAG_OVERLOAD]  = (r.codes.c == WIN_HIGH) && (r.codes.s == WIN_LOW);
        r.diagnosis[DIAG_BLOCKED]   = (r.codes.c == WIN_HIGH) && (r.codes.s == WIN_OFF);
      end
    end
    r.normal_total = seen_normal;
    r.fault_total  = seen_fault;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] rand_stamp();
    logic [63:0] r;
    r = {$urandom, $urandom};
    r[63:TIME_W] = '0;
    if (r > STAMP_TOP) r[TIME_W-1] = 1'b0;
    return r[TIME_W-1:0];
  endfunction

  function automatic logic signed [SW-1:0] pick_reading(input int hi, input int lo);
    int k;
    int x;
    k = $urandom_range(99);
    if (k < 45) begin
      if (hi >= lo) x = lo + int'($urandom_range(hi - lo));
      else x = int'($urandom);
    end else if (k < 53) x = 0;
    else if (k < 60) x = hi;
    else if (k < 67) x = hi + 1;
    else if (k < 74) x = lo;
    else if (k < 81) x = lo - 1;
    else if (k < 86) x = SMAX;
    else if (k < 90) x = SMIN;
    else x = int'($urandom);
    return SW'(x);
  endfunction

  function automatic sample_t gen_sample(input sample_t prev);
    sample_t x;
    x = prev;
    x.stamp = rand_stamp();
    // mostly fresh readings; the rest repeat the previous sample's readings
    if ($urandom_range(99) >= 15) begin
      x.temp  = pick_reading(lim_hi[CH_TEMP], lim_lo[CH_TEMP]);
      x.volt  = pick_reading(lim_hi[CH_VOLT], lim_lo[CH_VOLT]);
      x.curr  = pick_reading(lim_hi[CH_CURR], lim_lo[CH_CURR]);
      x.speed = pick_reading(lim_hi[CH_SPEED], lim_lo[CH_SPEED]);
    end
    return x;
  endfunction

  task automatic push_sample(input logic [TIME_W-1:0] st, input int t, input int v,
                             input int c, input int s);
    pending.push_back({st, SW'(t), SW'(v), SW'(c), SW'(s)});
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= SW'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TEMP_MAX:  lim_hi[CH_TEMP]  = SW'(value);
      REG_TEMP_MIN:  lim_lo[CH_TEMP]  = SW'(value);
      REG_VOLT_MAX:  lim_hi[CH_VOLT]  = SW'(value);
      REG_VOLT_MIN:  lim_lo[CH_VOLT]  = SW'(value);
      REG_CURR_MAX:  lim_hi[CH_CURR]  = SW'(value);
      REG_CURR_MIN:  lim_lo[CH_CURR]  = SW'(value);
      REG_SPEED_MAX: lim_hi[CH_SPEED] = SW'(value);
      REG_SPEED_MIN: lim_lo[CH_SPEED] = SW'(value);
      default: ;
    endcase
  endtask

  task automatic stray_write();
    cfg_write(CFG_IDX_W'(NUM_REGS + $urandom_range((1 << CFG_IDX_W) - 1 - NUM_REGS)),
              int'($urandom));
  endtask

  task automatic program_limits(input int th, input int tl, input int vh, input int vl,
                                input int ch, input int cl, input int sh, input int sl);
    cfg_write(REG_TEMP_MAX, th);
    cfg_write(REG_TEMP_MIN, tl);
    cfg_write(REG_VOLT_MAX, vh);
    cfg_write(REG_VOLT_MIN, vl);
    cfg_write(REG_CURR_MAX, ch);
    cfg_write(REG_CURR_MIN, cl);
    cfg_write(REG_SPEED_MAX, sh);
    cfg_write(REG_SPEED_MIN, sl);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending.size() != 0 || results_due.size() != 0 || in_valid) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input lim_mode_t mode, input bit quiet, input bit hold);
    int hi [NUM_CH];
    int lo [NUM_CH];
    int a;
    int b;
    settle();
    for (int ch = 0; ch < NUM_CH; ch++) begin
      a = int'($urandom_range(65535)) + SMIN;
      b = int'($urandom_range(65535)) + SMIN;
      case (mode)
        LIM_WIDE:      begin hi[ch] = SMAX; lo[ch] = SMIN; end
        LIM_INVERTED:  begin hi[ch] = SMIN; lo[ch] = SMAX; end
        LIM_ORDERED:   begin hi[ch] = (a > b) ? a : b; lo[ch] = (a > b) ? b : a; end
        LIM_SCRAMBLED: begin hi[ch] = a; lo[ch] = b; end
        default:       begin hi[ch] = a; lo[ch] = a; end
      endcase
    end
    stray_write();
    program_limits(hi[CH_TEMP], lo[CH_TEMP], hi[CH_VOLT], lo[CH_VOLT],
                   hi[CH_CURR], lo[CH_CURR], hi[CH_SPEED], lo[CH_SPEED]);
    no_idle = quiet;
    for (int k = 0; k < CHUNKS; k++) begin
      for (int i = 0; i < CHUNK; i++) begin
        last_gen = gen_sample(last_gen);
        pending.push_back(last_gen);
      end
      if (hold && k == 0) hold_req = 1'b1;
      // sender stops until the block has handed back everything
      if (k % 2 == 1) drain();
    end
    drain();
    no_idle = 1'b0;
  endtask

  // input side: new word offered at the falling edge
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (pending.size() != 0 && (no_idle || $urandom_range(99) >= 8)) begin
        cur_word = pending.pop_front();
        in_sample_time <= cur_word.stamp;
        in_temperature <= cur_word.temp;
        in_voltage     <= cur_word.volt;
        in_current     <= cur_word.curr;
        in_speed       <= cur_word.speed;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      results_due.push_back(judge_sample({in_sample_time, in_temperature, in_voltage,
                                          in_current, in_speed}));
      in_taken = 1'b1;
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 8);
    end
  end

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    mwfm_result_t due;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result word with nothing expected");
        failures++;
      end else begin
        due = results_due.pop_front();
        compare_field("temp_code", due.codes.t, out_temp_code);
        compare_field("volt_code", due.codes.v, out_volt_code);
        compare_field("curr_code", due.codes.c, out_curr_code);
        compare_field("speed_code", due.codes.s, out_speed_code);
        compare_field("fault_code", due.fault_code, out_fault_code);
        compare_field("in_limits", due.in_limits, out_in_limits);
        compare_field("new_report", due.new_report, out_new_report);
        compare_field("diagnosis", due.diagnosis, out_diagnosis);
        compare_field("normal_total", due.normal_total, out_normal_total);
        compare_field("fault_total", due.fault_total, out_fault_total);
        compare_field("fault_time", due.fault_time, out_fault_time);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      lim_hi[ch] = SW'(SMAX);
      lim_lo[ch] = SW'(SMIN);
    end
    seen_normal = '0;
    seen_fault = '0;
    prev_fault_code = CODE_NONE;
    last_gen = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset limits: only off and normal codes are possible
    push_sample('0, 0, 0, 0, 0);
    push_sample(STAMP_TOP[TIME_W-1:0], SMAX, SMAX, SMAX, SMAX);
    push_sample(rand_stamp(), SMIN, SMIN, SMIN, SMIN);
    push_sample(rand_stamp(), 1, -1, 1, -1);
    push_sample(rand_stamp(), 'h100, 0, 'h100, 'h100);
    push_sample(rand_stamp(), 'h100, 0, 'h100, 'h100);
    push_sample(rand_stamp(), 'h100, 'h100, 0, 0);
    push_sample({TIME_W{1'b1}} >> 1, -1, -1, -1, -1);
    settle();

    // tight windows, plus a write to an unmapped index that must be ignored
    program_limits('h5000, -'h0A00, 'h1800, 'h0C00, 'h0400, -'h0400, 'h7000, 'h0100);
    stray_write();
    @(negedge clk);
    cfg_valid <= 1'b0;
    push_sample(rand_stamp(), 'h1000, 'h1000, 'h0100, 'h2000);
    push_sample(rand_stamp(), -'h0B00, 'h1000, 'h0100, 'h2000);
    push_sample(rand_stamp(), 'h5001, 'h1000, 'h0100, 'h2000);
    push_sample(rand_stamp(), 'h5000, 'h1000, 'h0100, 'h2000);
    push_sample(rand_stamp(), -'h0A00, 'h0C00, -'h0400, 'h0100);
    push_sample(rand_stamp(), 'h1000, 'h0B00, 'h0100, 'h2000);
    push_sample(rand_stamp(), 'h1000, 'h1801, 'h0100, 'h2000);
    push_sample(rand_stamp(), 'h1000, 'h1000, 'h0500, 'h0080);
    push_sample(rand_stamp(), 'h1000, 'h1000, 'h0500, 0);
    push_sample(rand_stamp(), 'h1000, 'h1000, 'h0500, 0);
    push_sample(rand_stamp(), 'h1000, 0, 'h0500, 0);
    push_sample(rand_stamp(), SMIN, SMAX, SMIN, SMAX);
    push_sample(rand_stamp(), 'h1000, 'h1000, 'h0100, 'h2000);

    run_phase(LIM_ORDERED, 1'b0, 1'b0);
    run_phase(LIM_WIDE, 1'b0, 1'b0);
    run_phase(LIM_ORDERED, 1'b1, 1'b0);
    run_phase(LIM_INVERTED, 1'b0, 1'b0);
    run_phase(LIM_ORDERED, 1'b0, 1'b1);
    run_phase(LIM_SCRAMBLED, 1'b0, 1'b0);
    run_phase(LIM_POINT, 1'b0, 1'b0);
    run_phase(LIM_ORDERED, 1'b0, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    failures += results_due.size();
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
